>>> src/antialiased_disc_pixel_shader_core_assert.svh
// Assertion macros used by the disc shader top level.
`ifndef ANTIALIASED_DISC_PIXEL_SHADER_CORE_ASSERT_SVH
`define ANTIALIASED_DISC_PIXEL_SHADER_CORE_ASSERT_SVH

// Check that cons holds whenever ante holds.
`define ADPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that cond never holds.
`define ADPS_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

>>> src/adps_pkg.sv
// Constants, types and codes of the antialiased disc pixel shader.
`default_nettype none

package adps_pkg;

    localparam int COORD_BITS     = 11;
    localparam int DIST_FRAC_BITS = 8;
    localparam int RADIUS_W       = 10;
    localparam int COLOR_W        = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd4;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd16;
    localparam logic [COLOR_W-1:0]  COLOR_RESET  = 8'hff;

    localparam int H_W      = COORD_BITS + 1;
    localparam int SQR_W    = 2 * COORD_BITS + 1;
    localparam int Q_W      = 2 * COORD_BITS + 2;
    localparam int THR_W    = 2 * RADIUS_W + 3;
    localparam int CMP_W    = (Q_W > THR_W) ? Q_W : THR_W;
    localparam int BAND_Q_W = 2 * RADIUS_W + 2;

    localparam int SQ_W    = RADIUS_W + DIST_FRAC_BITS;
    localparam int SQ_IN_W = 2 * SQ_W;
    localparam int REM_W   = SQ_W + 2;

    localparam int DIFF_W          = RADIUS_W + 1 + DIST_FRAC_BITS;
    localparam int ALPHA_GAIN_SHIFT = 7;
    localparam int PROD_W          = DIFF_W + ALPHA_GAIN_SHIFT;
    localparam int SCALED_W        = PROD_W - DIST_FRAC_BITS;
    localparam logic [COLOR_W-1:0] ALPHA_MAX = 8'd254;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_BAND     = 2'd1,
        REGION_OUTSIDE  = 2'd2
    } region_t;

    typedef struct packed {
        region_t               region;
        logic [BAND_Q_W-1:0]   band_q;
    } queue_entry_t;

endpackage

`default_nettype wire

>>> src/adps_if.sv
// Pixel request and pixel result channel interfaces.
`default_nettype none

interface adps_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [adps_pkg::COORD_BITS-1:0] offset_x;
    logic signed [adps_pkg::COORD_BITS-1:0] offset_y;

    modport source (output valid, output offset_x, output offset_y, input ready);
    modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

interface adps_out_if;
    logic                          valid;
    logic                          ready;
    logic [adps_pkg::COLOR_W-1:0]  pixel_red;
    logic [adps_pkg::COLOR_W-1:0]  pixel_green;
    logic [adps_pkg::COLOR_W-1:0]  pixel_blue;
    logic [adps_pkg::COLOR_W-1:0]  pixel_alpha;
    logic [1:0]                    pixel_region;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    output pixel_alpha, output pixel_region, input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    input pixel_alpha, input pixel_region, output ready);
endinterface

`default_nettype wire

>>> src/antialiased_disc_pixel_shader_core.sv
// Top level of the antialiased disc pixel shader.
//
// A pixel request on pixel_in carries offset_x and offset_y relative to the disc
// centre. Each request yields exactly one result on pixel_out: the fill colour,
// the coverage alpha and the region code (interior, edge band, outside).
// Both channels use valid/ready; a request moves when both are high.
// Registers are written over cfg_write_en / cfg_index / cfg_data; the user must
// write them only while no request is in flight (not enforced by the block).
// Indexes past the last register are ignored. Throughput is one request per cycle
// while pixel_out does not stall. A request passes two front stages, the queue, an
// input register, a square-root stage per distance bit, ramp and output registers.
// When pixel_out stalls, the back end holds and the four-entry queue absorbs the
// front end; pixel_in.ready drops once the queue is full.
// Reset clears all pipeline valids and the queue and loads radius 16 and an
// opaque white fill.
`default_nettype none
`include "antialiased_disc_pixel_shader_core_assert.svh"

module antialiased_disc_pixel_shader_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    adps_in_if.sink                               pixel_in,
    adps_out_if.source                            pixel_out,
    input  wire logic                             cfg_write_en,
    input  wire logic [adps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [adps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [adps_pkg::RADIUS_W-1:0]  radius_reg;
    logic [adps_pkg::COLOR_W-1:0]   fill_red_reg;
    logic [adps_pkg::COLOR_W-1:0]   fill_green_reg;
    logic [adps_pkg::COLOR_W-1:0]   fill_blue_reg;
    logic [adps_pkg::COLOR_W-1:0]   fill_alpha_reg;

    logic                           push;
    adps_pkg::queue_entry_t         push_data;
    logic                           full;
    logic                           pop;
    adps_pkg::queue_entry_t         head;
    logic                           empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= adps_pkg::RADIUS_RESET;
            fill_red_reg   <= adps_pkg::COLOR_RESET;
            fill_green_reg <= adps_pkg::COLOR_RESET;
            fill_blue_reg  <= adps_pkg::COLOR_RESET;
            fill_alpha_reg <= adps_pkg::COLOR_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                adps_pkg::CFG_RADIUS: radius_reg     <= cfg_data[adps_pkg::RADIUS_W-1:0];
                adps_pkg::CFG_RED:    fill_red_reg   <= cfg_data[adps_pkg::COLOR_W-1:0];
                adps_pkg::CFG_GREEN:  fill_green_reg <= cfg_data[adps_pkg::COLOR_W-1:0];
                adps_pkg::CFG_BLUE:   fill_blue_reg  <= cfg_data[adps_pkg::COLOR_W-1:0];
                adps_pkg::CFG_ALPHA:  fill_alpha_reg <= cfg_data[adps_pkg::COLOR_W-1:0];
                default:              ;
            endcase
        end
    end

    adps_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pixel_in),
        .radius    (radius_reg),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    adps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    adps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .radius     (radius_reg),
        .fill_red   (fill_red_reg),
        .fill_green (fill_green_reg),
        .fill_blue  (fill_blue_reg),
        .fill_alpha (fill_alpha_reg),
        .pixel_out  (pixel_out)
    );

    `ADPS_ASSERT_IMPLY(a_interior_alpha, clk, rst_n, pixel_out.valid && (pixel_out.pixel_region == adps_pkg::REGION_INTERIOR), pixel_out.pixel_alpha == fill_alpha_reg)
    `ADPS_ASSERT_IMPLY(a_outside_alpha, clk, rst_n, pixel_out.valid && (pixel_out.pixel_region == adps_pkg::REGION_OUTSIDE), pixel_out.pixel_alpha == '0)
    `ADPS_ASSERT_NEVER(a_band_alpha_max, clk, rst_n, pixel_out.valid && (pixel_out.pixel_region == adps_pkg::REGION_BAND) && (pixel_out.pixel_alpha > adps_pkg::ALPHA_MAX))

endmodule

`default_nettype wire

>>> src/adps_front.sv
// Front end: half-pixel offsets, squared distance and region classification.
`default_nettype none

module adps_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    adps_in_if.sink                              pixel_in,
    input  wire logic [adps_pkg::RADIUS_W-1:0]   radius,
    output logic                                 push,
    output adps_pkg::queue_entry_t               push_data,
    input  wire logic                            full
);

    logic                                    front_adv;
    logic                                    s1_valid_reg;
    logic                                    s2_valid_reg;
    logic signed [adps_pkg::H_W-1:0]         hx_reg;
    logic signed [adps_pkg::H_W-1:0]         hy_reg;
    logic signed [2*adps_pkg::H_W-1:0]       sqx_full;
    logic signed [2*adps_pkg::H_W-1:0]       sqy_full;
    logic [adps_pkg::SQR_W-1:0]              sqx_reg;
    logic [adps_pkg::SQR_W-1:0]              sqy_reg;

    logic [adps_pkg::RADIUS_W-1:0]           rm1;
    logic [adps_pkg::RADIUS_W:0]             rp1;
    logic [2*adps_pkg::RADIUS_W-1:0]         rm1_sq;
    logic [2*adps_pkg::RADIUS_W+1:0]         rp1_sq;
    logic [2*adps_pkg::RADIUS_W+3:0]         outer_full;
    logic [adps_pkg::THR_W-1:0]              inner_reg;
    logic [adps_pkg::THR_W-1:0]              outer_reg;
    logic                                    radius_zero_reg;

    logic [adps_pkg::Q_W-1:0]                q;
    logic [adps_pkg::CMP_W-1:0]              q_cmp;
    adps_pkg::region_t                       region;

    assign front_adv      = !s2_valid_reg || !full;
    assign pixel_in.ready = front_adv;
    assign push           = s2_valid_reg && !full;

    // Region thresholds follow the radius register.
    assign rm1        = radius - adps_pkg::RADIUS_W'(1);
    assign rp1        = {1'b0, radius} + (adps_pkg::RADIUS_W + 1)'(1);
    assign rm1_sq     = rm1 * rm1;
    assign rp1_sq     = rp1 * rp1;
    assign outer_full = {rp1_sq, 2'b00};

    always_ff @(posedge clk)
    begin
        inner_reg       <= adps_pkg::THR_W'({rm1_sq, 2'b00});
        outer_reg       <= outer_full[adps_pkg::THR_W-1:0];
        radius_zero_reg <= (radius == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (front_adv)
        begin
            s1_valid_reg <= pixel_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign sqx_full = hx_reg * hx_reg;
    assign sqy_full = hy_reg * hy_reg;

    // Half-pixel units: 2*offset plus one when the radius is even.
    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            hx_reg  <= {pixel_in.offset_x, ~radius[0]};
            hy_reg  <= {pixel_in.offset_y, ~radius[0]};
            sqx_reg <= sqx_full[adps_pkg::SQR_W-1:0];
            sqy_reg <= sqy_full[adps_pkg::SQR_W-1:0];
        end
    end

    assign q     = adps_pkg::Q_W'(sqx_reg) + adps_pkg::Q_W'(sqy_reg);
    assign q_cmp = adps_pkg::CMP_W'(q);

    always_comb
    begin
        if (!radius_zero_reg && (q_cmp <= adps_pkg::CMP_W'(inner_reg)))
            region = adps_pkg::REGION_INTERIOR;
        else if (q_cmp >= adps_pkg::CMP_W'(outer_reg))
            region = adps_pkg::REGION_OUTSIDE;
        else
            region = adps_pkg::REGION_BAND;
    end

    assign push_data.region = region;
    assign push_data.band_q = q_cmp[adps_pkg::BAND_Q_W-1:0];

endmodule

`default_nettype wire

>>> src/adps_queue.sv
// Short request queue between the front end and the back end.
`default_nettype none

module adps_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire adps_pkg::queue_entry_t  push_data,
    output logic                         full,
    input  wire logic                    pop,
    output adps_pkg::queue_entry_t       head,
    output logic                         empty
);

    adps_pkg::queue_entry_t          entries_reg [adps_pkg::QUEUE_DEPTH];
    logic [adps_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [adps_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [adps_pkg::QUEUE_AW:0]     count_reg;
    logic [adps_pkg::QUEUE_AW:0]     count_next;

    assign full  = (count_reg == (adps_pkg::QUEUE_AW + 1)'(adps_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (adps_pkg::QUEUE_AW + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (adps_pkg::QUEUE_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + adps_pkg::QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + adps_pkg::QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

>>> src/adps_back.sv
// Back end: pipelined square root, edge ramp and the output register.
`default_nettype none

module adps_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire adps_pkg::queue_entry_t         head,
    input  wire logic                           empty,
    output logic                                pop,
    input  wire logic [adps_pkg::RADIUS_W-1:0]  radius,
    input  wire logic [adps_pkg::COLOR_W-1:0]   fill_red,
    input  wire logic [adps_pkg::COLOR_W-1:0]   fill_green,
    input  wire logic [adps_pkg::COLOR_W-1:0]   fill_blue,
    input  wire logic [adps_pkg::COLOR_W-1:0]   fill_alpha,
    adps_out_if.source                          pixel_out
);

    typedef struct packed {
        adps_pkg::region_t                region;
        logic [adps_pkg::SQ_IN_W-1:0]     operand;
        logic [adps_pkg::REM_W-1:0]       rem;
        logic [adps_pkg::SQ_W-1:0]        root;
    } sqrt_stage_t;

    logic                                back_adv;
    logic [adps_pkg::SQ_W+1:0]           vld_reg;
    sqrt_stage_t                         st_reg  [adps_pkg::SQ_W+1];
    sqrt_stage_t                         st_next [adps_pkg::SQ_W+1];

    logic [adps_pkg::RADIUS_W:0]         rp1;
    logic [adps_pkg::DIFF_W:0]           diff_full;
    logic [adps_pkg::DIFF_W-1:0]         diff_next;
    logic [adps_pkg::DIFF_W-1:0]         diff_reg;
    adps_pkg::region_t                   diff_region_reg;

    logic [adps_pkg::PROD_W-1:0]         prod;
    logic [adps_pkg::SCALED_W-1:0]       band_scaled;
    logic [adps_pkg::COLOR_W-1:0]        band_alpha;
    logic [adps_pkg::COLOR_W-1:0]        alpha_next;
    logic [adps_pkg::COLOR_W-1:0]        alpha_reg;
    adps_pkg::region_t                   region_reg;
    logic                                out_valid_reg;

    assign back_adv = !out_valid_reg || pixel_out.ready;
    assign pop      = back_adv && !empty;

    always_comb
    begin
        st_next[0].region  = head.region;
        st_next[0].operand = {head.band_q, {(2*adps_pkg::DIST_FRAC_BITS-2){1'b0}}};
        st_next[0].rem     = '0;
        st_next[0].root    = '0;
    end

    // One root bit per stage, two operand bits brought down each time.
    for (genvar k = 0; k < adps_pkg::SQ_W; k++)
    begin : g_sqrt
        logic [adps_pkg::REM_W-1:0] rem_shift;
        logic [adps_pkg::REM_W-1:0] trial;

        always_comb
        begin
            rem_shift = {st_reg[k].rem[adps_pkg::REM_W-3:0],
                         st_reg[k].operand[adps_pkg::SQ_IN_W-1-2*k -: 2]};
            trial     = {st_reg[k].root, 2'b01};
            st_next[k+1] = st_reg[k];
            if (rem_shift >= trial)
            begin
                st_next[k+1].rem  = rem_shift - trial;
                st_next[k+1].root = {st_reg[k].root[adps_pkg::SQ_W-2:0], 1'b1};
            end
            else
            begin
                st_next[k+1].rem  = rem_shift;
                st_next[k+1].root = {st_reg[k].root[adps_pkg::SQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            for (int i = 0; i <= adps_pkg::SQ_W; i++)
                st_reg[i] <= st_next[i];
        end
    end

    // Distance from the outer edge, floored at zero.
    assign rp1       = {1'b0, radius} + (adps_pkg::RADIUS_W + 1)'(1);
    assign diff_full = {1'b0, rp1, {adps_pkg::DIST_FRAC_BITS{1'b0}}}
                     - (adps_pkg::DIFF_W + 1)'(st_reg[adps_pkg::SQ_W].root);
    assign diff_next = diff_full[adps_pkg::DIFF_W] ? '0 : diff_full[adps_pkg::DIFF_W-1:0];

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            diff_reg        <= diff_next;
            diff_region_reg <= st_reg[adps_pkg::SQ_W].region;
        end
    end

    // Ramp gain of 127 as a shift and subtract.
    assign prod = {diff_reg, {adps_pkg::ALPHA_GAIN_SHIFT{1'b0}}}
                - {{adps_pkg::ALPHA_GAIN_SHIFT{1'b0}}, diff_reg};
    assign band_scaled = prod[adps_pkg::PROD_W-1:adps_pkg::DIST_FRAC_BITS];
    assign band_alpha  = (band_scaled > adps_pkg::SCALED_W'(adps_pkg::ALPHA_MAX))
                       ? adps_pkg::ALPHA_MAX : band_scaled[adps_pkg::COLOR_W-1:0];

    always_comb
    begin
        case (diff_region_reg)
            adps_pkg::REGION_INTERIOR: alpha_next = fill_alpha;
            adps_pkg::REGION_BAND:     alpha_next = band_alpha;
            default:                   alpha_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            alpha_reg  <= alpha_next;
            region_reg <= diff_region_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            vld_reg       <= {vld_reg[adps_pkg::SQ_W:0], !empty};
            out_valid_reg <= vld_reg[adps_pkg::SQ_W+1];
        end
    end

    assign pixel_out.valid        = out_valid_reg;
    assign pixel_out.pixel_red    = fill_red;
    assign pixel_out.pixel_green  = fill_green;
    assign pixel_out.pixel_blue   = fill_blue;
    assign pixel_out.pixel_alpha  = alpha_reg;
    assign pixel_out.pixel_region = region_reg;

endmodule

`default_nettype wire

>>> bench/antialiased_disc_pixel_shader_core_tb.sv
// Self-checking testbench for the antialiased disc pixel shader core.
`timescale 1ns / 1ps

module antialiased_disc_pixel_shader_core_tb;

    import adps_pkg::*;

    localparam int NUM_ROWS     = 29;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 100;
    localparam int HOLD_AT      = 350;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE       = 30;
    localparam int ALPHA_GAIN   = 127;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic                   is_write;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        logic [COORD_BITS-1:0]  off_x;
        logic [COORD_BITS-1:0]  off_y;
        logic                   known;
        logic [COLOR_W-1:0]     want_alpha;
        region_t                want_region;
    } stim_row_t;

    typedef struct {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
        region_t            region;
    } pixel_exp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [RADIUS_W-1:0] disc_radius = RADIUS_RESET;
    logic [COLOR_W-1:0]  fill_red    = COLOR_RESET;
    logic [COLOR_W-1:0]  fill_green  = COLOR_RESET;
    logic [COLOR_W-1:0]  fill_blue   = COLOR_RESET;
    logic [COLOR_W-1:0]  fill_alpha  = COLOR_RESET;

    pixel_exp_t pending_pixels[$];
    int         failures = 0;
    int         requests_sent = 0;
    bit         quiet = 1'b0;
    bit         hold_done = 1'b0;
    int         hold_left = 0;
    int         stall_left = 0;

    adps_in_if  pixel_req ();
    adps_out_if pixel_res ();

    antialiased_disc_pixel_shader_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_in     (pixel_req),
        .pixel_out    (pixel_res),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd0,    11'sd0,    1'b1, 8'hff, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    11'h400,   11'h400,   1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b0, CFG_RADIUS, 10'd0,    11'h3ff,   11'h3ff,   1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b0, CFG_RADIUS, 10'd0,    11'h400,   11'h3ff,   1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b0, CFG_RADIUS, 10'd0,    11'h3ff,   11'h400,   1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b0, CFG_RADIUS, 10'd0,    -11'sd15,  11'sd0,    1'b1, 8'hff, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    -11'sd16,  11'sd0,    1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd15,   11'sd0,    1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    -11'sd17,  11'sd0,    1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    -11'sd18,  11'sd0,    1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd11,   11'sd10,   1'b0, 8'h00, REGION_BAND},
        '{1'b1, CFG_RADIUS, 10'd0,    11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd0,    11'sd0,    1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    -11'sd1,   -11'sd1,   1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd0,    11'sd1,    1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b1, CFG_RADIUS, 10'd1023, 11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b1, CFG_ALPHA,  10'd0,    11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b1, CFG_RED,    10'd0,    11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b1, CFG_GREEN,  10'h080,  11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b1, CFG_BLUE,   10'h0ff,  11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd0,    11'sd0,    1'b1, 8'h00, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    11'h3ff,   11'sd0,    1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    11'h400,   11'h400,   1'b1, 8'h00, REGION_OUTSIDE},
        '{1'b0, CFG_RADIUS, 10'd0,    -11'sd1023, 11'sd0,   1'b0, 8'h00, REGION_BAND},
        '{1'b1, CFG_SPARE_FIRST, 10'h3ff, 11'sd0, 11'sd0,   1'b0, 8'h00, REGION_INTERIOR},
        '{1'b1, CFG_RADIUS, 10'd1,    11'sd0,    11'sd0,    1'b0, 8'h00, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd0,    11'sd0,    1'b1, 8'h00, REGION_INTERIOR},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd0,    -11'sd1,   1'b0, 8'h00, REGION_BAND},
        '{1'b0, CFG_RADIUS, 10'd0,    11'sd2,    11'sd0,    1'b1, 8'h00, REGION_OUTSIDE}
    };

    function automatic longint root_floor(input longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic pixel_exp_t shade_pixel(input logic [COORD_BITS-1:0] ox,
                                               input logic [COORD_BITS-1:0] oy);
        longint     r;
        longint     half;
        longint     hx;
        longint     hy;
        longint     q;
        longint     root_dist;
        longint     diff;
        longint     ramp;
        pixel_exp_t px;
        r    = longint'(disc_radius);
        half = disc_radius[0] ? 0 : 1;
        hx   = 2 * longint'($signed(ox)) + half;
        hy   = 2 * longint'($signed(oy)) + half;
        q    = hx * hx + hy * hy;
        px.red   = fill_red;
        px.green = fill_green;
        px.blue  = fill_blue;
        if (r != 0 && q <= 4 * (r - 1) * (r - 1))
        begin
            px.alpha  = fill_alpha;
            px.region = REGION_INTERIOR;
        end
        else if (q < 4 * (r + 1) * (r + 1))
        begin
            root_dist = root_floor(q << (2 * DIST_FRAC_BITS - 2));
            diff = ((r + 1) << DIST_FRAC_BITS) - root_dist;
            if (diff < 0)
                diff = 0;
            ramp = (ALPHA_GAIN * diff) >>> DIST_FRAC_BITS;
            if (ramp > longint'(ALPHA_MAX))
                ramp = longint'(ALPHA_MAX);
            px.alpha  = ramp[COLOR_W-1:0];
            px.region = REGION_BAND;
        end
        else
        begin
            px.alpha  = '0;
            px.region = REGION_OUTSIDE;
        end
        return px;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        pixel_req.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(posedge clk);
        case (idx)
            CFG_RADIUS: disc_radius = val[RADIUS_W-1:0];
            CFG_RED:    fill_red    = val[COLOR_W-1:0];
            CFG_GREEN:  fill_green  = val[COLOR_W-1:0];
            CFG_BLUE:   fill_blue   = val[COLOR_W-1:0];
            CFG_ALPHA:  fill_alpha  = val[COLOR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] ox, input logic [COORD_BITS-1:0] oy,
                              input logic known, input logic [COLOR_W-1:0] want_alpha,
                              input region_t want_region);
        pixel_exp_t px;
        int         gap;
        cfg_write_en <= 1'b0;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 19);
        if (gap != 0)
        begin
            pixel_req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_req.valid    <= 1'b1;
        pixel_req.offset_x <= ox;
        pixel_req.offset_y <= oy;
        do
            @(posedge clk);
        while (!pixel_req.ready);
        px = shade_pixel(ox, oy);
        if (known)
        begin
            px.alpha  = want_alpha;
            px.region = want_region;
        end
        pending_pixels.push_back(px);
        requests_sent++;
    endtask

    initial
    begin : stimulus
        int r;
        int a;
        int b;
        int mode;
        int sx;
        int sy;
        int tmp;
        pixel_req.valid    <= 1'b0;
        pixel_req.offset_x <= '0;
        pixel_req.offset_y <= '0;
        cfg_write_en       <= 1'b0;
        cfg_index          <= CFG_RADIUS;
        cfg_data           <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            else
                send_pixel(directed_rows[i].off_x, directed_rows[i].off_y,
                           directed_rows[i].known, directed_rows[i].want_alpha,
                           directed_rows[i].want_region);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: write_reg(CFG_RADIUS, 10'd1);
                1: write_reg(CFG_RADIUS, 10'd1023);
                2: write_reg(CFG_RADIUS, 10'd0);
                3: write_reg(CFG_RADIUS, 10'd2);
                4: write_reg(CFG_RADIUS, 10'd1022);
                5: write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(0, 1023)));
                default: write_reg(CFG_RADIUS, CFG_DATA_W'($urandom_range(3, 64)));
            endcase
            if (ph == 0)
            begin
                write_reg(CFG_RED, '0);
                write_reg(CFG_GREEN, '0);
                write_reg(CFG_BLUE, '0);
                write_reg(CFG_ALPHA, '0);
            end
            else if (ph == 1)
            begin
                write_reg(CFG_RED, 10'h0ff);
                write_reg(CFG_GREEN, 10'h0ff);
                write_reg(CFG_BLUE, 10'h0ff);
                write_reg(CFG_ALPHA, 10'h0ff);
            end
            else
            begin
                write_reg(CFG_RED, CFG_DATA_W'($urandom_range(0, 255)));
                write_reg(CFG_GREEN, CFG_DATA_W'($urandom_range(0, 255)));
                write_reg(CFG_BLUE, CFG_DATA_W'($urandom_range(0, 255)));
                write_reg(CFG_ALPHA, CFG_DATA_W'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
                          CFG_DATA_W'($urandom_range(0, 1023)));
            quiet = (ph == NUM_PHASES - 1);
            r = int'(disc_radius);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 7)
                begin
                    a = $urandom_range(0, r + 1);
                    b = (a <= r) ? int'(root_floor(longint'(r * r - a * a))) : 0;
                    sx = a + int'($urandom_range(0, 4)) - 2;
                    sy = b + int'($urandom_range(0, 4)) - 2;
                    if ($urandom_range(0, 1) == 1)
                        sx = -sx;
                    if ($urandom_range(0, 1) == 1)
                        sy = -sy;
                    if ($urandom_range(0, 1) == 1)
                    begin
                        tmp = sx;
                        sx  = sy;
                        sy  = tmp;
                    end
                end
                else if (mode < 9)
                begin
                    sx = int'($urandom_range(0, 2 * r + 1)) - (r + 1);
                    sy = int'($urandom_range(0, 2 * r + 1)) - (r + 1);
                end
                else
                begin
                    sx = int'($urandom_range(0, 2047)) - 1024;
                    sy = int'($urandom_range(0, 2047)) - 1024;
                end
                if (sx < -1024) sx = -1024;
                if (sx > 1023)  sx = 1023;
                if (sy < -1024) sy = -1024;
                if (sy > 1023)  sy = 1023;
                send_pixel(COORD_BITS'(sx), COORD_BITS'(sy), 1'b0, '0, REGION_INTERIOR);
            end
        end

        pixel_req.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (failures == 0 && pending_pixels.size() == 0)
            $display("antialiased_disc_pixel_shader_core_tb OK");
        else
            $display("antialiased_disc_pixel_shader_core_tb NOT OK");
        $finish;
    end

    always @(posedge clk)
    begin : result_check
        pixel_exp_t want;
        if (rst_n)
        begin
            if (pixel_res.valid && pixel_res.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel result with no request pending");
                    failures++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pixel_res.pixel_red !== want.red)
                    begin
                        $error("pixel_red: expected %0d, got %0d", want.red, pixel_res.pixel_red);
                        failures++;
                    end
                    if (pixel_res.pixel_green !== want.green)
                    begin
                        $error("pixel_green: expected %0d, got %0d", want.green,
                               pixel_res.pixel_green);
                        failures++;
                    end
                    if (pixel_res.pixel_blue !== want.blue)
                    begin
                        $error("pixel_blue: expected %0d, got %0d", want.blue, pixel_res.pixel_blue);
                        failures++;
                    end
                    if (pixel_res.pixel_alpha !== want.alpha)
                    begin
                        $error("pixel_alpha: expected %0d, got %0d", want.alpha,
                               pixel_res.pixel_alpha);
                        failures++;
                    end
                    if (pixel_res.pixel_region !== want.region)
                    begin
                        $error("pixel_region: expected %0d, got %0d", want.region,
                               pixel_res.pixel_region);
                        failures++;
                    end
                end
            end
            // hold off long enough to fill the block and stall the request side
            if (!hold_done && requests_sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pixel_res.ready <= 1'b0;
            end
            else if (quiet)
                pixel_res.ready <= 1'b1;
            else if (stall_left != 0)
            begin
                stall_left--;
                pixel_res.ready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                pixel_res.ready <= 1'b0;
            end
            else
                pixel_res.ready <= 1'b1;
        end
        else
            pixel_res.ready <= 1'b0;
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (pixel_req.valid && pixel_req.ready)
                || (pixel_res.valid && pixel_res.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("antialiased_disc_pixel_shader_core_tb NOT OK");
        $finish;
    end

endmodule
